// File: hdl/ffva_pkg.sv
// Shared constants and the route token type for the first-fit vehicle assigner.
`timescale 1ns / 1ps
`default_nettype none

package ffva_pkg;

  localparam int MAX_UNITS_DEFAULT = 64;

  localparam int STATION_W = 12;
  localparam int TIME_W    = 24;
  localparam int UNIT_W    = 6;
  localparam int COUNT_W   = 7;

  // Route request as it travels along the cell row, with the search flags so far.
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic                 fresh;
    logic                 last;
    logic [STATION_W-1:0] origin;
    logic [STATION_W-1:0] terminal;
    logic [TIME_W-1:0]    start;
    logic [TIME_W-1:0]    fin;
  } tok_t;

endpackage

`default_nettype wire

// File: hdl/ffva_cell.sv
// One vehicle slot cell: holds the slot state and passes the route request onward.
`timescale 1ns / 1ps
`default_nettype none

module ffva_cell #(
  parameter int MAX_UNITS = ffva_pkg::MAX_UNITS_DEFAULT,
  parameter int INDEX     = 0
) (
  input  wire  logic                                   clk,
  input  wire  logic                                   rst,
  input  wire  logic                                   en,
  input  wire  ffva_pkg::tok_t                         tok_in,
  input  wire  logic [$clog2(MAX_UNITS)-1:0]           pick_in,
  input  wire  logic [$clog2(MAX_UNITS+1)-1:0]         count_in,
  output ffva_pkg::tok_t                               tok_out,
  output logic [$clog2(MAX_UNITS)-1:0]                 pick_out,
  output logic [$clog2(MAX_UNITS+1)-1:0]               count_out
);

  localparam int IW = $clog2(MAX_UNITS);
  localparam int CW = $clog2(MAX_UNITS + 1);

  logic                           used;
  logic [ffva_pkg::STATION_W-1:0] terminal;
  logic [ffva_pkg::TIME_W-1:0]    fin_time;
  logic                           hit;
  logic                           used_after;

  // First fit: only a request that has not been placed yet may claim this slot.
  assign hit = tok_in.valid && !tok_in.found &&
               (!used || ((terminal == tok_in.origin) && (tok_in.start > fin_time)));
  assign used_after = used || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (en) begin
      if (hit) begin
        used     <= 1'b1;
        terminal <= tok_in.terminal;
        fin_time <= tok_in.fin;
      end
      // drop the slot once the last route of a batch has gone past
      if (tok_in.valid && tok_in.last) begin
        used <= 1'b0;
      end
      tok_out.valid    <= tok_in.valid;
      tok_out.found    <= tok_in.found || hit;
      tok_out.fresh    <= tok_in.fresh || (hit && !used);
      tok_out.last     <= tok_in.last;
      tok_out.origin   <= tok_in.origin;
      tok_out.terminal <= tok_in.terminal;
      tok_out.start    <= tok_in.start;
      tok_out.fin      <= tok_in.fin;
      pick_out         <= hit ? IW'(INDEX) : pick_in;
      count_out        <= count_in + CW'(used_after);
    end
  end

endmodule

`default_nettype wire

// File: hdl/first_fit_vehicle_assigner.sv
// Top level of the first-fit vehicle assigner: a row of slot cells and the result port.
//
// Usage: present a route request on the input channel (in_valid / in_ready) with
// origin_station, terminal_station, depart_time, arrive_time and batch_end. The
// request walks a row of MAX_UNITS slot cells, one cell per cycle unless the row
// is stalled; each cell holds one vehicle slot. The first cell that is unused, or
// whose last route ended at this origin strictly before this start, takes the
// request and records its terminal and end time. Every cell that is in use adds
// itself to the running slot count, so units_in_use leaves the row complete.
// The accepting edge loads the first cell's register; the request then passes
// through each cell's register in turn, and the last one drives out_valid.
// Throughput: one request per cycle while the receiver keeps up; a request
// following directly behind sees each slot after the one ahead has updated it,
// set by the one-cell-per-cycle advance of the row.
// A route flagged batch_end clears each slot as it passes, after its own
// result, so the next batch starts with an empty table.
// Reset (rst, synchronous) empties every slot and the whole row of requests.
// When the receiver stalls (out_valid high, out_ready low) the whole row holds,
// and in_ready drops until the waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_vehicle_assigner #(
  parameter int MAX_UNITS = ffva_pkg::MAX_UNITS_DEFAULT
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst,
  input  wire  logic                           in_valid,
  output logic                                 in_ready,
  input  wire  logic [ffva_pkg::STATION_W-1:0] origin_station,
  input  wire  logic [ffva_pkg::STATION_W-1:0] terminal_station,
  input  wire  logic [ffva_pkg::TIME_W-1:0]    depart_time,
  input  wire  logic [ffva_pkg::TIME_W-1:0]    arrive_time,
  input  wire  logic                           batch_end,
  output logic                                 out_valid,
  input  wire  logic                           out_ready,
  output logic [ffva_pkg::UNIT_W-1:0]          unit_index,
  output logic                                 opened_new,
  output logic                                 no_unit,
  output logic [ffva_pkg::COUNT_W-1:0]         units_in_use
);

  localparam int IW = $clog2(MAX_UNITS);
  localparam int CW = $clog2(MAX_UNITS + 1);

  logic                           en;
  ffva_pkg::tok_t                 tok_chain   [0:MAX_UNITS];
  logic [IW-1:0]                  pick_chain  [0:MAX_UNITS];
  logic [CW-1:0]                  count_chain [0:MAX_UNITS];
  ffva_pkg::tok_t                 res_tok;
  logic [IW+ffva_pkg::UNIT_W-1:0] pick_wide;
  logic [CW+ffva_pkg::COUNT_W-1:0] count_wide;

  // Advance the whole row unless a finished result is waiting to be taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Head of the row: a new request with nothing found yet.
  assign tok_chain[0].valid    = in_valid;
  assign tok_chain[0].found    = 1'b0;
  assign tok_chain[0].fresh    = 1'b0;
  assign tok_chain[0].last     = batch_end;
  assign tok_chain[0].origin   = origin_station;
  assign tok_chain[0].terminal = terminal_station;
  assign tok_chain[0].start    = depart_time;
  assign tok_chain[0].fin      = arrive_time;
  assign pick_chain[0]         = '0;
  assign count_chain[0]        = '0;

  for (genvar k = 0; k < MAX_UNITS; k++) begin : g_cell
    ffva_cell #(
      .MAX_UNITS (MAX_UNITS),
      .INDEX     (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .tok_in    (tok_chain[k]),
      .pick_in   (pick_chain[k]),
      .count_in  (count_chain[k]),
      .tok_out   (tok_chain[k+1]),
      .pick_out  (pick_chain[k+1]),
      .count_out (count_chain[k+1])
    );
  end

  // The last cell's output register is the result register.
  assign res_tok    = tok_chain[MAX_UNITS];
  assign pick_wide  = {{ffva_pkg::UNIT_W{1'b0}}, pick_chain[MAX_UNITS]};
  assign count_wide = {{ffva_pkg::COUNT_W{1'b0}}, count_chain[MAX_UNITS]};

  assign out_valid    = res_tok.valid;
  assign unit_index   = res_tok.found ? pick_wide[ffva_pkg::UNIT_W-1:0] : '0;
  assign opened_new   = res_tok.fresh;
  assign no_unit      = !res_tok.found;
  assign units_in_use = count_wide[ffva_pkg::COUNT_W-1:0];

  // A freshly opened slot is always the next one in fill order.
  a_fresh_is_next: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_tok.fresh) |->
      ({1'b0, count_chain[MAX_UNITS]} == ({1'b0, pick_chain[MAX_UNITS]} + (CW+1)'(1))))
    else $error("opened slot does not match slot count");

  // No slot is only reported when every slot is in use.
  a_none_means_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_tok.found) |-> (count_chain[MAX_UNITS] == CW'(MAX_UNITS)))
    else $error("no vehicle reported with free slots");

  // A fresh slot implies the route was placed.
  a_fresh_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_tok.fresh) |-> res_tok.found)
    else $error("fresh flag without placement");

  // A stalled result holds its slot number.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(pick_chain[MAX_UNITS]))
    else $error("result changed under stall");

endmodule

`default_nettype wire
